>>> design/irclt_pkg.sv
// Package for the line token tagger: beat types, phase and role codes,
// and the parameter count limit. No dependencies.
`default_nettype none

package irclt_pkg;

    // Parameter counter limit; clamped so it fits the 6-bit count fields
    localparam int PARAM_COUNT_MAX = 63;
    localparam int CNT_W           = 6;
    localparam logic [CNT_W-1:0] CountLimit =
        CNT_W'((PARAM_COUNT_MAX > 63) ? 63 : PARAM_COUNT_MAX);

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Input mode codes (the fourth code ends the line like MODE_END)
    localparam logic [1:0] MODE_BYTE = 2'd0;
    localparam logic [1:0] MODE_LAST = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_PREFIX  = 3'd1,
        PH_CMDWAIT = 3'd2,
        PH_CMD     = 3'd3,
        PH_GAP     = 3'd4,
        PH_MIDDLE  = 3'd5,
        PH_TRAIL   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_NONE         = 3'd0,
        ROLE_PREFIX_COLON = 3'd1,
        ROLE_PREFIX_CHAR  = 3'd2,
        ROLE_CMD_CHAR     = 3'd3,
        ROLE_MIDDLE_CHAR  = 3'd4,
        ROLE_TRAIL_COLON  = 3'd5,
        ROLE_TRAIL_CHAR   = 3'd6
    } role_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] char_in;
    } in_t;

    typedef struct packed {
        logic [2:0]       role;
        logic             token_start;
        logic [CNT_W-1:0] param_index;
        logic             line_done;
        logic             command_present;
        logic [CNT_W-1:0] param_count;
        logic             has_trailing;
        logic             malformed;
    } out_t;

    // Line parse state carried from byte to byte
    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] param_counter;
        logic             trailing_seen;
        logic             command_seen;
    } state_t;

    localparam state_t StateReset = '{
        phase:         PH_START,
        param_counter: '0,
        trailing_seen: 1'b0,
        command_seen:  1'b0
    };

endpackage : irclt_pkg

`default_nettype wire

>>> design/irclt_step.sv
// Combinational step of the tagger: classifies one beat against the
// current line state and gives the result and the next state. Uses irclt_pkg.
`default_nettype none

module irclt_step (
    input  irclt_pkg::state_t state_cur,
    input  irclt_pkg::in_t    beat,
    output irclt_pkg::state_t state_nxt,
    output irclt_pkg::out_t   result
);
    import irclt_pkg::*;

    logic             is_colon;
    logic             is_space;
    logic [CNT_W-1:0] cnt_open;
    logic [CNT_W-1:0] idx_open;
    logic [CNT_W-1:0] idx_cur;
    state_t           st;
    role_t            role;
    logic             start;
    logic [CNT_W-1:0] pidx;

    assign is_colon = (beat.char_in == CH_COLON);
    assign is_space = (beat.char_in == CH_SPACE);

    // Counter after opening a parameter, and the index it gives
    assign cnt_open = (state_cur.param_counter < CountLimit) ?
                      state_cur.param_counter + CNT_W'(1) : state_cur.param_counter;
    assign idx_open = (cnt_open == '0) ? '0 : cnt_open - CNT_W'(1);
    assign idx_cur  = (state_cur.param_counter == '0) ? '0 :
                      state_cur.param_counter - CNT_W'(1);

    // Byte classification by phase
    always_comb begin
        st    = state_cur;
        role  = ROLE_NONE;
        start = 1'b0;
        pidx  = '0;
        if (beat.mode[1] == 1'b0) begin
            unique case (state_cur.phase)
                PH_START: begin
                    if (is_colon) begin
                        role     = ROLE_PREFIX_COLON;
                        start    = 1'b1;
                        st.phase = PH_PREFIX;
                    end else if (is_space) begin
                        st.phase = PH_CMDWAIT;
                    end else begin
                        role            = ROLE_CMD_CHAR;
                        start           = 1'b1;
                        st.command_seen = 1'b1;
                        st.phase        = PH_CMD;
                    end
                end
                PH_PREFIX: begin
                    if (is_space) st.phase = PH_CMDWAIT;
                    else          role     = ROLE_PREFIX_CHAR;
                end
                PH_CMDWAIT: begin
                    if (!is_space) begin
                        role            = ROLE_CMD_CHAR;
                        start           = 1'b1;
                        st.command_seen = 1'b1;
                        st.phase        = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (is_space) st.phase = PH_GAP;
                    else          role     = ROLE_CMD_CHAR;
                end
                PH_GAP: begin
                    if (is_colon) begin
                        st.param_counter = cnt_open;
                        role             = ROLE_TRAIL_COLON;
                        start            = 1'b1;
                        pidx             = idx_open;
                        st.trailing_seen = 1'b1;
                        st.phase         = PH_TRAIL;
                    end else if (!is_space) begin
                        st.param_counter = cnt_open;
                        role             = ROLE_MIDDLE_CHAR;
                        start            = 1'b1;
                        pidx             = idx_open;
                        st.phase         = PH_MIDDLE;
                    end
                end
                PH_MIDDLE: begin
                    if (is_space) begin
                        st.phase = PH_GAP;
                    end else begin
                        role = ROLE_MIDDLE_CHAR;
                        pidx = idx_cur;
                    end
                end
                PH_TRAIL: begin
                    role = ROLE_TRAIL_CHAR;
                    pidx = idx_cur;
                end
                default: begin
                    st = StateReset;
                end
            endcase
        end
    end

    // Line end: summary from the updated state (malformed if still in the prefix), then back to line start
    always_comb begin
        result                 = '0;
        result.role            = role;
        result.token_start     = start;
        result.param_index     = pidx;
        state_nxt              = st;
        if (beat.mode != MODE_BYTE) begin
            result.line_done = 1'b1;
            if (st.phase == PH_PREFIX) begin
                result.malformed = 1'b1;
            end else begin
                result.command_present = st.command_seen;
                result.param_count     = st.param_counter;
                result.has_trailing    = st.trailing_seen;
            end
            state_nxt = StateReset;
        end
    end

endmodule : irclt_step

`default_nettype wire

>>> design/irc_line_token_tagger.sv
// Top level of the line token tagger: input register, line state register,
// result register and handshakes. Uses irclt_pkg and irclt_step.
`default_nettype none

// Tags each byte of a CR LF stripped line with its role (prefix, command,
// middle parameter, trailing) and, on the beat that ends the line, reports
// the line summary. The block takes one byte per clock while the output is
// not held by m_ready: a beat is captured in the input register, classified
// combinationally against the line state, and lands in the result register.
// The state register is updated on the same edge as the result register.
// While a result waits in the output register, one more input beat is taken
// only if the input register is empty.
module irc_line_token_tagger (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  irclt_pkg::in_t   s_data,
    output logic             m_valid,
    input  wire              m_ready,
    output irclt_pkg::out_t  m_data
);
    import irclt_pkg::*;

    in_t    in_reg;
    logic   in_valid_reg;
    logic   in_valid_next;
    out_t   out_reg;
    logic   out_valid_reg;
    logic   out_valid_next;
    state_t state_reg;
    state_t state_next;
    out_t   result;
    logic   advance;
    logic   s_fire;

    // Move the held beat into the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    irclt_step u_step (
        .state_cur (state_reg),
        .beat      (in_reg),
        .state_nxt (state_next),
        .result    (result)
    );

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= StateReset;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire)  in_reg  <= s_data;
        if (advance) out_reg <= result;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef ASSERT_OFF
    // A line end always returns the parser to line start
    a_line_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.mode != MODE_BYTE) |=>
            (state_reg.phase == PH_START && state_reg.param_counter == '0
             && !state_reg.trailing_seen && !state_reg.command_seen))
        else $error("state not cleared after line end");

    // Parameter counter saturates at the limit
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.param_counter <= CountLimit)
        else $error("parameter counter beyond limit");

    // Summary fields are zero on beats that do not end the line
    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.line_done) |->
            (!m_data.command_present && m_data.param_count == '0
             && !m_data.has_trailing && !m_data.malformed))
        else $error("summary fields set mid-line");

    // An unterminated prefix reports an empty message
    a_malformed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.malformed) |->
            (!m_data.command_present && m_data.param_count == '0
             && !m_data.has_trailing))
        else $error("malformed line carries message fields");

    // Token starts only on token-opening roles
    a_start_roles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.token_start) |->
            (m_data.role == ROLE_PREFIX_COLON || m_data.role == ROLE_CMD_CHAR
             || m_data.role == ROLE_MIDDLE_CHAR || m_data.role == ROLE_TRAIL_COLON))
        else $error("token start on wrong role");
`endif

endmodule : irc_line_token_tagger

`default_nettype wire
